[design/tih_pkg.sv]
// ----------------------------------------------------------------------------
// TCP ISN HMAC package
// Shared constants, types and SHA-256 helpers for the ISN generator.
// ----------------------------------------------------------------------------
`default_nettype none
package tih_pkg;

   localparam int TICKS_PER_QUANTUM_DEF = 4;

   localparam logic [1:0] REQ_TICK    = 2'd0;
   localparam logic [1:0] REQ_GEN     = 2'd1;
   localparam logic [1:0] REQ_READ    = 2'd2;
   localparam logic [1:0] REQ_RESTORE = 2'd3;

   localparam logic [7:0] FAMILY_V4 = 8'd4;
   localparam logic [7:0] FAMILY_V6 = 8'd6;

   // block loaded into the compression unit
   localparam logic [1:0] BLK_IKEY = 2'd0;
   localparam logic [1:0] BLK_MSG  = 2'd1;
   localparam logic [1:0] BLK_OKEY = 2'd2;
   localparam logic [1:0] BLK_OUT  = 2'd3;

   typedef struct packed {
      logic       load;       // load schedule from block, chain from IV or chain
      logic       from_iv;
      logic [1:0] blk_sel;
      logic       round;      // run one round
      logic       fold;       // add round vars into chain
      logic       save_inner; // keep inner digest
   } dp_cmd_type;

   typedef struct packed {
      logic last_round;
   } dp_sts_type;

   localparam logic [255:0] INIT_H = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k;
      case (t)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

[design/tcp_isn_hmac_generator.sv]
// ----------------------------------------------------------------------------
// TCP ISN HMAC generator
// ISN = quantum clock + first digest word of HMAC-SHA-256 over the tuple.
// ----------------------------------------------------------------------------
// Tick, read and restore items need no compression. A generate item runs
// four SHA-256 compressions (inner key, message, outer key, inner digest) on
// one shared round unit at one round per cycle. One item is in work at a
// time; the next is taken once the result register has been emptied.
`default_nettype none
module tcp_isn_hmac_generator
   import tih_pkg::*;
#(
   parameter int TICKS_PER_QUANTUM = TICKS_PER_QUANTUM_DEF
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata: is_ipv6[0], local_addr_hi[64:1], local_addr_lo[128:65],
   //        lcl_port[144:129], remote_addr_hi[208:145],
   //        remote_addr_lo[272:209], rmt_port[288:273],
   //        restore_quanta[320:289], zero pad to 328
   input  wire logic [327:0] req_tdata,
   // tuser: req_type[1:0]
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata: isn[31:0], cur_quanta[63:32], secret_valid[64],
   //        restore_ok[65], zero pad to 72
   output logic [71:0]       rsp_tdata,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [4:0]   csr_paddr,
   input  wire logic [63:0]  csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int PW = (TICKS_PER_QUANTUM > 1) ? $clog2(TICKS_PER_QUANTUM) : 1;

   logic [63:0]   secret_ff [4];
   logic [PW-1:0] phase_ff;
   logic [31:0]   quanta_ff;
   logic          rsp_valid_ff;
   logic [71:0]   rsp_data_ff;
   logic          gen_pend_ff;
   logic [511:0]  msg_ff;

   logic          accept, secret_nz, start, busy, done;
   dp_cmd_type    cmd;
   dp_sts_type    sts;
   logic [31:0]   digest;
   logic [511:0]  msg_in;
   logic [1:0]    rq;

   assign csr_pready = 1'b1;
   assign csr_prdata = secret_ff[csr_paddr[4:3]];
   assign secret_nz  = |{secret_ff[0], secret_ff[1], secret_ff[2], secret_ff[3]};

   assign rq         = req_tuser;
   assign req_tready = !rsp_valid_ff && !busy && !gen_pend_ff;
   assign accept     = req_tvalid && req_tready;
   assign start      = gen_pend_ff && !busy;

   // message block with padding; total length is 64 key bytes + message
   always_comb begin
      if (req_tdata[0]) begin
         msg_in = {FAMILY_V6, req_tdata[64:1], req_tdata[128:65], req_tdata[144:129],
                   req_tdata[208:145], req_tdata[272:209], req_tdata[288:273],
                   8'h80, 144'd0, 64'd808};
      end else begin
         msg_in = {FAMILY_V4, req_tdata[96:65], req_tdata[144:129],
                   req_tdata[240:209], req_tdata[288:273],
                   8'h80, 336'd0, 64'd616};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) secret_ff[i] <= '0;
         phase_ff     <= '0;
         quanta_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         gen_pend_ff  <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            secret_ff[csr_paddr[4:3]] <= csr_pwdata;
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (start) gen_pend_ff <= 1'b0;
         if (done) begin
            rsp_valid_ff      <= 1'b1;
            rsp_data_ff[31:0] <= quanta_ff + digest;
         end
         if (accept) begin
            rsp_data_ff[64]    <= secret_nz;
            rsp_data_ff[71:66] <= '0;
            case (rq)
               REQ_TICK: begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_data_ff[31:0]  <= '0;
                  rsp_data_ff[65]    <= 1'b0;
                  if (phase_ff == PW'(TICKS_PER_QUANTUM - 1)) begin
                     phase_ff              <= '0;
                     quanta_ff             <= quanta_ff + 32'd1;
                     rsp_data_ff[63:32]    <= quanta_ff + 32'd1;
                  end else begin
                     phase_ff              <= phase_ff + PW'(1);
                     rsp_data_ff[63:32]    <= quanta_ff;
                  end
               end
               REQ_GEN: begin
                  gen_pend_ff        <= 1'b1;
                  msg_ff             <= msg_in;
                  rsp_data_ff[63:32] <= quanta_ff;
                  rsp_data_ff[65]    <= 1'b0;
               end
               REQ_READ: begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_data_ff[31:0]  <= '0;
                  rsp_data_ff[63:32] <= quanta_ff;
                  rsp_data_ff[65]    <= 1'b0;
               end
               REQ_RESTORE: begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_data_ff[31:0] <= '0;
                  rsp_data_ff[65]   <= secret_nz;
                  if (secret_nz) begin
                     quanta_ff          <= req_tdata[320:289];
                     phase_ff           <= '0;
                     rsp_data_ff[63:32] <= req_tdata[320:289];
                  end else begin
                     rsp_data_ff[63:32] <= quanta_ff;
                  end
               end
               default: rsp_valid_ff <= 1'b1;
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   tih_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy),
      .done  (done)
   );

   tih_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .key         ({secret_ff[0], secret_ff[1], secret_ff[2], secret_ff[3]}),
      .msg_block   (msg_ff),
      .sts         (sts),
      .digest_word (digest)
   );

endmodule
`default_nettype wire

[design/tih_datapath.sv]
// ----------------------------------------------------------------------------
// TCP ISN HMAC datapath
// SHA-256 compression unit, one round per cycle, with HMAC block assembly.
// ----------------------------------------------------------------------------
`default_nettype none
module tih_datapath
   import tih_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire dp_cmd_type   cmd,
   input  wire logic [255:0] key,
   input  wire logic [511:0] msg_block,
   output dp_sts_type        sts,
   output logic [31:0]       digest_word
);

   logic [255:0] chain_ff, chain_in;
   logic [255:0] vars_ff, vars_in;
   logic [511:0] sched_ff, sched_in;
   logic [255:0] inner_ff;
   logic [5:0]   round_ff, round_in;

   logic [511:0] ipad_blk, opad_blk, out_blk, sel_blk;
   logic [31:0]  w, a, b, c, d, e, f, g, h, t1, t2;
   logic [31:0]  wm2, wm7, wm15, wm16, s0, s1, wnew;

   assign ipad_blk = {key ^ {32{8'h36}}, {32{8'h36}}};
   assign opad_blk = {key ^ {32{8'h5c}}, {32{8'h5c}}};
   assign out_blk  = {inner_ff, 8'h80, 184'd0, 64'd768};

   always_comb begin
      case (cmd.blk_sel)
         BLK_IKEY: sel_blk = ipad_blk;
         BLK_MSG:  sel_blk = msg_block;
         BLK_OKEY: sel_blk = opad_blk;
         BLK_OUT:  sel_blk = out_blk;
         default:  sel_blk = msg_block;
      endcase
   end

   // schedule window: word 0 (top) is the current word
   always_comb begin
      w    = sched_ff[511:480];
      wm16 = sched_ff[511:480];
      wm15 = sched_ff[479:448];
      wm7  = sched_ff[223:192];
      wm2  = sched_ff[63:32];
      s0   = rotr(wm15, 7) ^ rotr(wm15, 18) ^ (wm15 >> 3);
      s1   = rotr(wm2, 17) ^ rotr(wm2, 19) ^ (wm2 >> 10);
      wnew = s1 + wm7 + s0 + wm16;
      {a, b, c, d, e, f, g, h} = vars_ff;
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + round_k(round_ff) + w;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
   end

   always_comb begin
      chain_in = chain_ff;
      vars_in  = vars_ff;
      sched_in = sched_ff;
      round_in = round_ff;
      if (cmd.load) begin
         chain_in = cmd.from_iv ? INIT_H : chain_ff;
         vars_in  = chain_in;
         sched_in = sel_blk;
         round_in = 6'd0;
      end else if (cmd.round) begin
         vars_in  = {t1 + t2, a, b, c, d + t1, e, f, g};
         sched_in = {sched_ff[479:0], wnew};
         round_in = round_ff + 6'd1;
      end else if (cmd.fold) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[32*i +: 32] = chain_ff[32*i +: 32] + vars_ff[32*i +: 32];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff <= 6'd0;
      end else begin
         round_ff <= round_in;
      end
      chain_ff <= chain_in;
      vars_ff  <= vars_in;
      sched_ff <= sched_in;
      if (cmd.save_inner) begin
         inner_ff <= chain_ff;
      end
   end

   assign sts.last_round = (round_ff == 6'd63);
   assign digest_word    = chain_ff[255:224];

endmodule
`default_nettype wire

[design/tih_controller.sv]
// ----------------------------------------------------------------------------
// TCP ISN HMAC controller
// Sequences the four compressions of one HMAC and the item handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module tih_controller
   import tih_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  start,
   input  dp_sts_type sts,
   output dp_cmd_type cmd,
   output logic       busy,
   output logic       done
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_DONE
   } state_type;

   state_type  state_ff;
   logic [1:0] blk_ff;

   always_comb begin
      cmd            = '0;
      cmd.blk_sel    = blk_ff;
      cmd.load       = (state_ff == ST_LOAD);
      cmd.from_iv    = (blk_ff == BLK_IKEY) || (blk_ff == BLK_OKEY);
      cmd.round      = (state_ff == ST_ROUND);
      cmd.fold       = (state_ff == ST_FOLD);
      cmd.save_inner = (state_ff == ST_LOAD) && (blk_ff == BLK_OKEY);
   end

   assign busy = (state_ff != ST_IDLE);
   assign done = (state_ff == ST_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         blk_ff   <= BLK_IKEY;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_LOAD;
                  blk_ff   <= BLK_IKEY;
               end
            end
            ST_LOAD:  state_ff <= ST_ROUND;
            ST_ROUND: begin
               if (sts.last_round) state_ff <= ST_FOLD;
            end
            ST_FOLD: begin
               if (blk_ff == BLK_OUT) begin
                  state_ff <= ST_DONE;
               end else begin
                  blk_ff   <= blk_ff + 2'd1;
                  state_ff <= ST_LOAD;
               end
            end
            ST_DONE:  state_ff <= ST_IDLE;
            default:  state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire
